// ===== rtl/core/orbit_guidance_step_top_macros.svh =====
// Assertion macros for the orbit guidance step block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef ORBIT_GUIDANCE_STEP_TOP_MACROS_SVH
`define ORBIT_GUIDANCE_STEP_TOP_MACROS_SVH
// Clocked assertion that is switched off while reset is asserted.
`define OGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define OGS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/core/ogs_pkg.sv =====
// Shared types, constants and functions for the orbit guidance step block.
// No dependencies; imported by every module of the block except the port checker.
package ogs_pkg;

  localparam int ANGLE_ITERATIONS = 24;
  localparam int ITER_W = $clog2(ANGLE_ITERATIONS + 1);
  localparam int K_W = 5;
  localparam int CW = 36;
  localparam int MA_W = 48;
  localparam int MB_W = 32;
  localparam int MP_W = 64;
  localparam int MB_CNT_W = $clog2(MB_W);
  localparam int DN_W = 64;
  localparam int DD_W = 34;
  localparam int DN_CNT_W = $clog2(DN_W);
  localparam int ADDR_W = 5;
  localparam int CENT_W = 53;
  localparam int ACC_W = 48;

  localparam logic signed [CW-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 36'sd652032874;
  localparam logic signed [63:0] CMD_LIMIT = 64'sh0000_4000_0000_0000;
  localparam logic [8:0] HALF_TURN_DEG = 9'd180;
  localparam logic [8:0] FULL_TURN_DEG = 9'd360;

  localparam logic signed [31:0] TARGET_X_RST = 32'sd6553600;
  localparam logic signed [31:0] TARGET_Y_RST = 32'sd3276800;
  localparam logic signed [31:0] START_X_RST = -32'sd9830400;
  localparam logic signed [31:0] START_Y_RST = 32'sd7864320;
  localparam logic signed [31:0] START_HEADING_RST = 32'sd1482810;
  localparam logic [23:0] SPEED_RST = 24'd262144;
  localparam logic [31:0] ORBIT_RADIUS_RST = 32'd1966080;
  localparam logic signed [23:0] GAIN_RST = 24'sd65536;

  typedef enum logic [2:0] {
    REG_TARGET_X = 3'd0,
    REG_TARGET_Y = 3'd1,
    REG_START_X = 3'd2,
    REG_START_Y = 3'd3,
    REG_START_HEADING = 3'd4,
    REG_SPEED = 3'd5,
    REG_ORBIT_RADIUS = 3'd6,
    REG_GAIN = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_heading;
    logic [23:0] speed;
    logic [31:0] orbit_radius;
    logic signed [23:0] gain;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic neg;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic [DN_W-1:0] dividend;
    logic [DD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic start;
    logic vect;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] z0;
  } cor_req_t;

  typedef struct packed {
    logic neg;
    logic signed [CW-1:0] z;
  } fold_t;

  typedef struct packed {
    logic clip;
    logic signed [31:0] val;
  } sat_t;

  function automatic logic [30:0] atan_entry(input logic [K_W-1:0] k);
    logic [30:0] v;
    case (k)
      5'd0: v = 31'd843314856;
      5'd1: v = 31'd497837829;
      5'd2: v = 31'd263043836;
      5'd3: v = 31'd133525158;
      5'd4: v = 31'd67021686;
      5'd5: v = 31'd33543515;
      5'd6: v = 31'd16775850;
      5'd7: v = 31'd8388437;
      5'd8: v = 31'd4194282;
      5'd9: v = 31'd2097149;
      5'd10: v = 31'd1048575;
      5'd11: v = 31'd524287;
      5'd12: v = 31'd262143;
      5'd13: v = 31'd131071;
      5'd14: v = 31'd65535;
      5'd15: v = 31'd32767;
      5'd16: v = 31'd16383;
      5'd17: v = 31'd8191;
      5'd18: v = 31'd4095;
      5'd19: v = 31'd2047;
      5'd20: v = 31'd1023;
      5'd21: v = 31'd511;
      5'd22: v = 31'd255;
      5'd23: v = 31'd127;
      5'd24: v = 31'd63;
      5'd25: v = 31'd31;
      5'd26: v = 31'd15;
      5'd27: v = 31'd7;
      5'd28: v = 31'd3;
      5'd29: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  function automatic fold_t fold_angle(input logic signed [CW-1:0] r);
    logic signed [CW-1:0] w;
    fold_t f;
    w = r;
    if (r > PI_Q30) begin
      w = r - TWO_PI_Q30;
    end else if (r < -PI_Q30) begin
      w = r + TWO_PI_Q30;
    end
    f.neg = 1'b0;
    f.z = w;
    if (w > HALF_PI_Q30) begin
      f.z = w - PI_Q30;
      f.neg = 1'b1;
    end else if (w < -HALF_PI_Q30) begin
      f.z = w + PI_Q30;
      f.neg = 1'b1;
    end
    return f;
  endfunction

  function automatic sat_t sat32(input logic signed [64:0] v);
    sat_t s;
    s.clip = 1'b0;
    s.val = v[31:0];
    if (v > 65'sd2147483647) begin
      s.clip = 1'b1;
      s.val = 32'sh7fff_ffff;
    end else if (v < -65'sd2147483648) begin
      s.clip = 1'b1;
      s.val = 32'sh8000_0000;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/ogs_regs.sv =====
// Configuration registers of the orbit guidance step block on an APB-style port.
// Depends on ogs_pkg for the register map, reset values and cfg_t.
module ogs_regs import ogs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_x <= TARGET_X_RST;
      cfg_r.target_y <= TARGET_Y_RST;
      cfg_r.start_x <= START_X_RST;
      cfg_r.start_y <= START_Y_RST;
      cfg_r.start_heading <= START_HEADING_RST;
      cfg_r.speed <= SPEED_RST;
      cfg_r.orbit_radius <= ORBIT_RADIUS_RST;
      cfg_r.gain <= GAIN_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_TARGET_X: cfg_r.target_x <= pwdata;
        REG_TARGET_Y: cfg_r.target_y <= pwdata;
        REG_START_X: cfg_r.start_x <= pwdata;
        REG_START_Y: cfg_r.start_y <= pwdata;
        REG_START_HEADING: cfg_r.start_heading <= pwdata;
        REG_SPEED: cfg_r.speed <= pwdata[23:0];
        REG_ORBIT_RADIUS: cfg_r.orbit_radius <= pwdata;
        REG_GAIN: cfg_r.gain <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TARGET_X: prdata = cfg_r.target_x;
      REG_TARGET_Y: prdata = cfg_r.target_y;
      REG_START_X: prdata = cfg_r.start_x;
      REG_START_Y: prdata = cfg_r.start_y;
      REG_START_HEADING: prdata = cfg_r.start_heading;
      REG_SPEED: prdata = {8'd0, cfg_r.speed};
      REG_ORBIT_RADIUS: prdata = cfg_r.orbit_radius;
      REG_GAIN: prdata = {8'd0, cfg_r.gain};
    endcase
  end

endmodule

// ===== rtl/core/ogs_serial_mul.sv =====
// Shift-and-add multiplier that takes one multiplier bit per cycle.
// Depends on ogs_pkg for widths and mul_req_t.
module ogs_serial_mul import ogs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mul_req_t               req,
  output logic signed [MP_W-1:0] prod,
  output logic                   done
);

  logic [MP_W-1:0]     a_r;
  logic [MB_W-1:0]     b_r;
  logic [MP_W-1:0]     acc_r;
  logic [MB_CNT_W-1:0] cnt_r;
  logic                run_r;
  logic                neg_r;
  logic                done_r;
  logic signed [MP_W-1:0] prod_r;
  logic [MP_W-1:0]     acc_nxt;

  assign acc_nxt = b_r[0] ? acc_r + a_r : acc_r;
  assign prod = prod_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r <= MP_W'(req.a);
        b_r <= req.b;
        acc_r <= '0;
        neg_r <= req.neg;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        acc_r <= acc_nxt;
        a_r <= {a_r[MP_W-2:0], 1'b0};
        b_r <= {1'b0, b_r[MB_W-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MB_CNT_W'(MB_W - 1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
          prod_r <= neg_r ? -$signed(acc_nxt) : $signed(acc_nxt);
        end
      end
    end
  end

endmodule

// ===== rtl/core/ogs_serial_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on ogs_pkg for widths and div_req_t.
module ogs_serial_div import ogs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  div_req_t        req,
  output logic [DN_W-1:0] quo,
  output logic [DD_W-1:0] rem,
  output logic            done
);

  logic [DN_W-1:0]     q_r;
  logic [DD_W-1:0]     rem_r;
  logic [DD_W-1:0]     dsr_r;
  logic [DN_CNT_W-1:0] cnt_r;
  logic                run_r;
  logic                done_r;
  logic [DD_W:0]       trial;
  logic [DD_W:0]       diff;
  logic                fits;

  assign trial = {rem_r, q_r[DN_W-1]};
  assign diff = trial - {1'b0, dsr_r};
  assign fits = trial >= {1'b0, dsr_r};
  assign quo = q_r;
  assign rem = rem_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        q_r <= req.dividend;
        dsr_r <= req.divisor;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= fits ? diff[DD_W-1:0] : trial[DD_W-1:0];
        q_r <= {q_r[DN_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DN_CNT_W'(DN_W - 1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/ogs_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, in rotation or vectoring mode.
// Depends on ogs_pkg for the arctangent table, widths and cor_req_t.
module ogs_cordic import ogs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cor_req_t             req,
  output logic signed [CW-1:0] x,
  output logic signed [CW-1:0] y,
  output logic signed [CW-1:0] z,
  output logic                 done
);

  logic signed [CW-1:0] x_r, y_r, z_r;
  logic [ITER_W-1:0]    iter_r;
  logic                 run_r;
  logic                 vect_r;
  logic                 done_r;
  logic [K_W-1:0]       k;
  logic signed [CW-1:0] xs, ys, at;
  logic                 m;

  assign k = K_W'(iter_r);
  assign xs = x_r >>> k;
  assign ys = y_r >>> k;
  assign at = $signed({{(CW-31){1'b0}}, atan_entry(k)});
  assign m = vect_r ? y_r[CW-1] : !z_r[CW-1];
  assign x = x_r;
  assign y = y_r;
  assign z = z_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        x_r <= req.x0;
        y_r <= req.y0;
        z_r <= req.z0;
        vect_r <= req.vect;
        iter_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        x_r <= m ? x_r - ys : x_r + ys;
        y_r <= m ? y_r + xs : y_r - xs;
        z_r <= m ? z_r - at : z_r + at;
        iter_r <= iter_r + 1'b1;
        if (iter_r == ITER_W'(ANGLE_ITERATIONS - 1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/orbit_guidance_step_top.sv =====
// Top level of the orbit guidance step block: sequencer, state and result register.
// Depends on ogs_pkg, ogs_regs, ogs_serial_mul, ogs_serial_div and ogs_cordic.
//
// One input word advances the vehicle by one guidance tick and yields one result word. The
// ATAN pass is skipped when the vehicle sits on the target and the D_DIV step when the speed
// is zero. The block takes no new word until it is through with the last one. A tick runs
// eight divisions on the shared one-bit-per-cycle divider, together with seven multiplications
// on the shared shift-and-add multiplier and three passes of the CORDIC unit. Input is taken
// only while the sequencer is idle; a finished result waits in the output register without
// blocking the next word. Configuration registers lie at byte address 4*i and are read and
// written with no wait states.
module orbit_guidance_step_top import ogs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_pos_x,
  output logic [31:0]       out_pos_y,
  output logic [31:0]       out_heading_out,
  output logic [10:0]       out_bearing_deg,
  output logic              out_saturated,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [20:0] {
    ST_IDLE   = 21'd1 << 0,
    ST_PREP   = 21'd1 << 1,
    ST_ATAN   = 21'd1 << 2,
    ST_PHI_MUL = 21'd1 << 3,
    ST_PHI_DIV = 21'd1 << 4,
    ST_PHI_MOD = 21'd1 << 5,
    ST_TH_MUL = 21'd1 << 6,
    ST_TH_DIV = 21'd1 << 7,
    ST_N_MUL  = 21'd1 << 8,
    ST_N_DIV  = 21'd1 << 9,
    ST_N_WRAP = 21'd1 << 10,
    ST_N_ROT  = 21'd1 << 11,
    ST_P_WRAP = 21'd1 << 12,
    ST_P_ROT  = 21'd1 << 13,
    ST_C_MUL  = 21'd1 << 14,
    ST_C_DIV  = 21'd1 << 15,
    ST_G_MUL  = 21'd1 << 16,
    ST_D_DIV  = 21'd1 << 17,
    ST_X_MUL  = 21'd1 << 18,
    ST_Y_MUL  = 21'd1 << 19,
    ST_FIN    = 21'd1 << 20
  } state_t;

  cfg_t     cfg;
  mul_req_t mreq;
  div_req_t dreq;
  cor_req_t creq;

  logic signed [MP_W-1:0] mul_p;
  logic                   mul_done;
  logic [DN_W-1:0]        div_q;
  logic [DD_W-1:0]        div_r;
  logic                   div_done;
  logic signed [CW-1:0]   cor_x, cor_y, cor_z;
  logic                   cor_done;

  state_t state_r;
  logic   issued_r;
  logic   restart_r;
  logic signed [31:0] cur_x_r, cur_y_r, cur_h_r;
  logic signed [33:0] dx_r, dy_r;
  logic signed [CW-1:0] theta_r, ang_r, sn_r, sp_r, cp_r;
  logic   fold_neg_r;
  logic signed [9:0] phi_g_r;
  logic signed [10:0] n_r;
  logic [CENT_W-1:0] cent_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [63:0] delta_r;
  logic signed [33:0] stepx_r, stepy_r;
  logic   out_valid_r;
  logic [31:0] out_x_r, out_y_r, out_h_r;
  logic [10:0] out_n_r;
  logic   out_sat_r;

  logic signed [31:0] eff_x, eff_y;
  logic   is_compute, skip, issue, fire, unit_done, dxy_zero, out_free;
  logic signed [CW-1:0] dx_e, dy_e;
  logic signed [42:0] phi_e;
  logic   phi_neg, theta_neg, sn_neg, gain_neg, acc_neg;
  logic [42:0] phi_mag;
  logic [CW-1:0] theta_mag, sn_mag, cp_mag, sp_mag;
  logic [10:0] n_mag;
  logic [24:0] gain_mag;
  logic [ACC_W-1:0] acc_abs;
  logic signed [9:0] rem10, q10, theta_g;
  logic signed [11:0] n_sum;
  logic signed [CW-1:0] rem_e;
  fold_t  fold;
  logic signed [63:0] acc_sum;
  logic [DD_W-1:0] radius_d;
  logic signed [64:0] sum_x, sum_y, sum_h;
  sat_t   sat_x, sat_y, sat_h;

  ogs_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  ogs_serial_mul u_mul (
    .clk(clk), .rst_n(rst_n), .req(mreq), .prod(mul_p), .done(mul_done)
  );

  ogs_serial_div u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq), .quo(div_q), .rem(div_r), .done(div_done)
  );

  ogs_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .req(creq), .x(cor_x), .y(cor_y), .z(cor_z), .done(cor_done)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_pos_x = out_x_r;
  assign out_pos_y = out_y_r;
  assign out_heading_out = out_h_r;
  assign out_bearing_deg = out_n_r;
  assign out_saturated = out_sat_r;
  assign out_free = !out_valid_r || !out_stall;

  assign eff_x = restart_r ? cfg.start_x : cur_x_r;
  assign eff_y = restart_r ? cfg.start_y : cur_y_r;
  assign dx_e = CW'(dx_r);
  assign dy_e = CW'(dy_r);
  assign dxy_zero = (dx_r == '0) && (dy_r == '0);

  assign phi_e = {cur_h_r[31], cur_h_r, 10'd0};
  assign phi_neg = cur_h_r[31];
  assign phi_mag = phi_neg ? 43'(-phi_e) : 43'(phi_e);
  assign theta_neg = theta_r[CW-1];
  assign theta_mag = theta_neg ? CW'(-theta_r) : CW'(theta_r);
  assign n_mag = n_r[10] ? 11'(-n_r) : 11'(n_r);
  assign sn_neg = sn_r[CW-1];
  assign sn_mag = sn_neg ? CW'(-sn_r) : CW'(sn_r);
  assign cp_mag = cp_r[CW-1] ? CW'(-cp_r) : CW'(cp_r);
  assign sp_mag = sp_r[CW-1] ? CW'(-sp_r) : CW'(sp_r);
  assign gain_neg = cfg.gain[23];
  assign gain_mag = gain_neg ? 25'(-{cfg.gain[23], cfg.gain}) : 25'({cfg.gain[23], cfg.gain});
  assign acc_neg = acc_r[ACC_W-1];
  assign acc_abs = acc_neg ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign radius_d = (cfg.orbit_radius == '0) ? DD_W'(1) : DD_W'(cfg.orbit_radius);

  assign rem10 = $signed(10'(div_r));
  assign q10 = $signed(10'(div_q));
  assign theta_g = theta_neg ? -q10 : q10;
  assign n_sum = $signed(12'(HALF_TURN_DEG)) - 12'(phi_g_r) - 12'(theta_g);
  assign rem_e = $signed(CW'(div_r));
  assign fold = fold_angle(ang_r);
  assign acc_sum = $signed(64'(cent_r)) + (mul_p >>> 26);

  assign sum_x = 65'(cur_x_r) + 65'(stepx_r);
  assign sum_y = 65'(cur_y_r) + 65'(stepy_r);
  assign sum_h = 65'(cur_h_r) - 65'(delta_r);
  assign sat_x = sat32(sum_x);
  assign sat_y = sat32(sum_y);
  assign sat_h = sat32(sum_h);

  assign is_compute = !(state_r == ST_IDLE || state_r == ST_PREP || state_r == ST_FIN);
  assign skip = (state_r == ST_ATAN && dxy_zero) ||
                (state_r == ST_D_DIV && cfg.speed == '0);
  assign issue = is_compute && !issued_r && !skip;
  assign unit_done = mul_done || div_done || cor_done;
  assign fire = issued_r && unit_done;

  always_comb begin
    mreq = '0;
    dreq = '0;
    creq = '0;
    unique case (state_r)
      ST_ATAN: begin
        creq.start = issue;
        creq.vect = 1'b1;
        creq.x0 = dy_r[33] ? -dy_e : dy_e;
        creq.y0 = dy_r[33] ? -dx_e : dx_e;
        creq.z0 = !dy_r[33] ? '0 : (dx_r[33] ? -PI_Q30 : PI_Q30);
      end
      ST_PHI_MUL: begin
        mreq.start = issue;
        mreq.a = MA_W'(phi_mag);
        mreq.b = MB_W'(HALF_TURN_DEG);
      end
      ST_PHI_DIV, ST_TH_DIV: begin
        dreq.start = issue;
        dreq.dividend = DN_W'(mul_p);
        dreq.divisor = DD_W'(PI_Q30);
      end
      ST_PHI_MOD: begin
        dreq.start = issue;
        dreq.dividend = div_q;
        dreq.divisor = DD_W'(FULL_TURN_DEG);
      end
      ST_TH_MUL: begin
        mreq.start = issue;
        mreq.a = MA_W'(theta_mag);
        mreq.b = MB_W'(HALF_TURN_DEG);
      end
      ST_N_MUL: begin
        mreq.start = issue;
        mreq.a = MA_W'(PI_Q30);
        mreq.b = MB_W'(n_mag);
      end
      ST_N_DIV: begin
        dreq.start = issue;
        dreq.dividend = DN_W'(mul_p);
        dreq.divisor = DD_W'(HALF_TURN_DEG);
      end
      ST_N_WRAP: begin
        dreq.start = issue;
        dreq.dividend = div_q;
        dreq.divisor = DD_W'(TWO_PI_Q30);
      end
      ST_P_WRAP: begin
        dreq.start = issue;
        dreq.dividend = DN_W'(phi_mag);
        dreq.divisor = DD_W'(TWO_PI_Q30);
      end
      ST_N_ROT, ST_P_ROT: begin
        creq.start = issue;
        creq.vect = 1'b0;
        creq.x0 = INV_GAIN_Q30;
        creq.y0 = '0;
        creq.z0 = fold.z;
      end
      ST_C_MUL: begin
        mreq.start = issue;
        mreq.a = MA_W'(cfg.speed);
        mreq.b = MB_W'(cfg.speed);
      end
      ST_C_DIV: begin
        dreq.start = issue;
        dreq.dividend = {mul_p[DN_W-5:0], 4'd0};
        dreq.divisor = radius_d;
      end
      ST_G_MUL: begin
        mreq.start = issue;
        mreq.neg = sn_neg ^ gain_neg;
        mreq.a = MA_W'(sn_mag);
        mreq.b = MB_W'(gain_mag);
      end
      ST_D_DIV: begin
        dreq.start = issue;
        dreq.dividend = DN_W'({acc_abs[ACC_W-2:0], 16'd0});
        dreq.divisor = DD_W'(cfg.speed);
      end
      ST_X_MUL: begin
        mreq.start = issue;
        mreq.neg = cp_r[CW-1];
        mreq.a = MA_W'(cp_mag);
        mreq.b = MB_W'(cfg.speed);
      end
      ST_Y_MUL: begin
        mreq.start = issue;
        mreq.neg = sp_r[CW-1];
        mreq.a = MA_W'(sp_mag);
        mreq.b = MB_W'(cfg.speed);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      issued_r <= 1'b0;
      out_valid_r <= 1'b0;
      cur_x_r <= START_X_RST;
      cur_y_r <= START_Y_RST;
      cur_h_r <= START_HEADING_RST;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      if (issue) begin
        issued_r <= 1'b1;
      end else if (fire) begin
        issued_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            restart_r <= in_restart;
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          cur_x_r <= eff_x;
          cur_y_r <= eff_y;
          if (restart_r) begin
            cur_h_r <= cfg.start_heading;
          end
          dx_r <= 34'(eff_x) - 34'(cfg.target_x);
          dy_r <= 34'(eff_y) - 34'(cfg.target_y);
          state_r <= ST_ATAN;
        end
        ST_ATAN: begin
          if (dxy_zero) begin
            theta_r <= '0;
            state_r <= ST_PHI_MUL;
          end else if (fire) begin
            theta_r <= cor_z;
            state_r <= ST_PHI_MUL;
          end
        end
        ST_PHI_MUL: if (fire) state_r <= ST_PHI_DIV;
        ST_PHI_DIV: if (fire) state_r <= ST_PHI_MOD;
        ST_PHI_MOD: begin
          if (fire) begin
            phi_g_r <= phi_neg ? -rem10 : rem10;
            state_r <= ST_TH_MUL;
          end
        end
        ST_TH_MUL: if (fire) state_r <= ST_TH_DIV;
        ST_TH_DIV: begin
          if (fire) begin
            n_r <= 11'(n_sum);
            state_r <= ST_N_MUL;
          end
        end
        ST_N_MUL: if (fire) state_r <= ST_N_DIV;
        ST_N_DIV: if (fire) state_r <= ST_N_WRAP;
        ST_N_WRAP: begin
          if (fire) begin
            ang_r <= n_r[10] ? -rem_e : rem_e;
            state_r <= ST_N_ROT;
          end
        end
        ST_N_ROT: begin
          if (issue) begin
            fold_neg_r <= fold.neg;
          end
          if (fire) begin
            sn_r <= fold_neg_r ? -cor_y : cor_y;
            state_r <= ST_P_WRAP;
          end
        end
        ST_P_WRAP: begin
          if (fire) begin
            ang_r <= phi_neg ? -rem_e : rem_e;
            state_r <= ST_P_ROT;
          end
        end
        ST_P_ROT: begin
          if (issue) begin
            fold_neg_r <= fold.neg;
          end
          if (fire) begin
            sp_r <= fold_neg_r ? -cor_y : cor_y;
            cp_r <= fold_neg_r ? -cor_x : cor_x;
            state_r <= ST_C_MUL;
          end
        end
        ST_C_MUL: if (fire) state_r <= ST_C_DIV;
        ST_C_DIV: begin
          if (fire) begin
            cent_r <= CENT_W'(div_q);
            state_r <= ST_G_MUL;
          end
        end
        ST_G_MUL: begin
          if (fire) begin
            if (acc_sum > CMD_LIMIT) begin
              acc_r <= ACC_W'(CMD_LIMIT);
            end else if (acc_sum < -CMD_LIMIT) begin
              acc_r <= ACC_W'(-CMD_LIMIT);
            end else begin
              acc_r <= ACC_W'(acc_sum);
            end
            state_r <= ST_D_DIV;
          end
        end
        ST_D_DIV: begin
          if (cfg.speed == '0) begin
            delta_r <= '0;
            state_r <= ST_X_MUL;
          end else if (fire) begin
            delta_r <= acc_neg ? -$signed(div_q) : $signed(div_q);
            state_r <= ST_X_MUL;
          end
        end
        ST_X_MUL: begin
          if (fire) begin
            stepx_r <= 34'(mul_p >>> 30);
            state_r <= ST_Y_MUL;
          end
        end
        ST_Y_MUL: begin
          if (fire) begin
            stepy_r <= 34'(mul_p >>> 30);
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            cur_x_r <= sat_x.val;
            cur_y_r <= sat_y.val;
            cur_h_r <= sat_h.val;
            out_x_r <= sat_x.val;
            out_y_r <= sat_y.val;
            out_h_r <= sat_h.val;
            out_n_r <= n_r;
            out_sat_r <= sat_x.clip || sat_y.clip || sat_h.clip;
            out_valid_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/orbit_guidance_step_checker.sv =====
// Port-level checker for the orbit guidance step block, bound to the top level.
// Depends on orbit_guidance_step_top_macros.svh for the assertion macros.
`include "orbit_guidance_step_top_macros.svh"

module orbit_guidance_step_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_restart,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_pos_x,
  input logic [31:0] out_pos_y,
  input logic [31:0] out_heading_out,
  input logic [10:0] out_bearing_deg,
  input logic        out_saturated
);

  `OGS_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid, "result word after reset")
  `OGS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_heading_out), "stalled result word changed")
  `OGS_ASSERT(a_done_frees_input, $rose(out_valid) |-> !in_stall, "input still stalled after result")
  `OGS_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second word taken while busy")
  `OGS_ASSERT(a_bearing_range, out_valid |-> ($signed(out_bearing_deg) >= -11'sd540 && $signed(out_bearing_deg) <= 11'sd900), "bearing out of range")

endmodule

bind orbit_guidance_step_top orbit_guidance_step_checker u_checker (.*);
